### rtl/trcc_pkg.sv
package trcc_pkg;

   localparam int unsigned CFG_BITS   = 12;
   localparam int unsigned STEP_BITS  = 8;
   localparam int unsigned KEY_BITS   = 8;
   localparam int unsigned MODE_BITS  = 2;
   localparam int unsigned OUT_BITS   = 12;
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 48;

   localparam int unsigned PULSE_BITS_DEFAULT = 12;
   // Wide enough for the widest supported level plus one step without wrapping.
   localparam int unsigned CALC_BITS = 17;

   localparam logic [CFG_BITS-1:0] NEUTRAL_RESET = 12'd1500;

   typedef logic [CALC_BITS-1:0] calc_type;
   typedef logic [STEP_BITS-1:0] step_type;

   localparam logic [MODE_BITS-1:0] MODE_MANUAL    = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_HOVER     = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_ROLL_LEFT = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_RESERVED  = 2'd3;

   localparam logic [KEY_BITS-1:0] KEY_FORWARD       = 8'h57;
   localparam logic [KEY_BITS-1:0] KEY_BACK          = 8'h53;
   localparam logic [KEY_BITS-1:0] KEY_FORWARD_LEFT  = 8'h51;
   localparam logic [KEY_BITS-1:0] KEY_FORWARD_RIGHT = 8'h45;
   localparam logic [KEY_BITS-1:0] KEY_BACK_LEFT     = 8'h41;
   localparam logic [KEY_BITS-1:0] KEY_BACK_RIGHT    = 8'h44;
   localparam logic [KEY_BITS-1:0] KEY_STOP          = 8'h50;
   localparam logic [KEY_BITS-1:0] KEY_UP            = 8'h49;
   localparam logic [KEY_BITS-1:0] KEY_DIVE          = 8'h4B;
   localparam logic [KEY_BITS-1:0] KEY_ROLL_LEFT     = 8'h4A;
   localparam logic [KEY_BITS-1:0] KEY_ROLL_RIGHT    = 8'h4C;

   localparam logic [CSR_INDEX_BITS-1:0] REG_REST_PULSE   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEER_CENTER = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEER_LIMITS = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SIDE_LIMITS  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_REAR_LIMITS  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SLOW_STEPS   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FAST_STEPS   = 3'd6;

   typedef struct packed {
      logic [11:0] rest_pulse;
      logic [11:0] steer_center;
      logic [23:0] steer_limits;
      logic [47:0] side_limits;
      logic [47:0] rear_limits;
      logic [31:0] slow_steps;
      logic [31:0] fast_steps;
   } cfg_type;

   function automatic calc_type up_to(calc_type lv, step_type step, calc_type tgt);
      calc_type s;
      s = lv + calc_type'(step);
      return (s < tgt) ? s : tgt;
   endfunction

   function automatic calc_type down_to(calc_type lv, step_type step, calc_type tgt);
      calc_type s;
      s = (lv > calc_type'(step)) ? lv - calc_type'(step) : '0;
      return (s > tgt) ? s : tgt;
   endfunction

   function automatic calc_type toward(calc_type lv, step_type step, calc_type tgt);
      if (lv > tgt) return down_to(lv, step, tgt);
      if (lv < tgt) return up_to(lv, step, tgt);
      return lv;
   endfunction

   function automatic calc_type ramp_up(calc_type lv, step_type slow, step_type fast,
                                        calc_type lim, calc_type rest);
      if (lv < rest) return up_to(lv, slow, rest);
      if (lv < lim) return up_to(lv, fast, lim);
      return lv;
   endfunction

   function automatic calc_type ramp_down(calc_type lv, step_type slow, step_type fast,
                                          calc_type lim, calc_type rest);
      if (lv > rest) return down_to(lv, slow, rest);
      if (lv > lim) return down_to(lv, fast, lim);
      return lv;
   endfunction

   function automatic calc_type turn_fwd(calc_type lv, step_type slow, step_type fast,
                                         calc_type tgt, calc_type rest);
      if (lv < rest) return up_to(lv, slow, rest);
      return toward(lv, fast, tgt);
   endfunction

   function automatic calc_type turn_rev(calc_type lv, step_type slow, step_type fast,
                                         calc_type tgt, calc_type rest);
      if (lv > rest) return down_to(lv, slow, rest);
      return toward(lv, fast, tgt);
   endfunction

endpackage

### rtl/thruster_ramp_command_controller.sv
// Ramps the left, right and rear thruster levels and the steering servo level once per
// command beat. A request beat is captured in an input register; when the response
// side is free or its result is being taken, the four levels are updated from it into
// the level registers, which drive the response port. One beat is taken every cycle while
// results are taken, the rate being set by the update loop through the four level
// registers; while a result waits, one further request can still enter the input
// register, after which the request side stalls until the waiting result is taken.
// The pulse outputs carry the low 12 bits of each level, and configuration
// writes take effect from the next update.
module thruster_ramp_command_controller #(
   parameter int unsigned PULSE_BITS = trcc_pkg::PULSE_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [trcc_pkg::MODE_BITS-1:0]       req_mode,
   input  logic [trcc_pkg::KEY_BITS-1:0]        req_left_key,
   input  logic [trcc_pkg::KEY_BITS-1:0]        req_right_key,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [trcc_pkg::OUT_BITS-1:0]        rsp_left_pulse,
   output logic [trcc_pkg::OUT_BITS-1:0]        rsp_right_pulse,
   output logic [trcc_pkg::OUT_BITS-1:0]        rsp_rear_pulse,
   output logic [trcc_pkg::OUT_BITS-1:0]        rsp_steer_pulse,
   input  logic                                 csr_write_enable,
   input  logic [trcc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [trcc_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);

   localparam logic [PULSE_BITS-1:0] LEVEL_RESET = PULSE_BITS'(trcc_pkg::NEUTRAL_RESET);

   trcc_pkg::cfg_type cfg;

   logic                             in_valid_ff;
   logic [trcc_pkg::MODE_BITS-1:0]   in_mode_ff;
   logic [trcc_pkg::KEY_BITS-1:0]    in_left_key_ff;
   logic [trcc_pkg::KEY_BITS-1:0]    in_right_key_ff;
   logic                             rsp_valid_ff;
   logic [PULSE_BITS-1:0]            left_level_ff, right_level_ff;
   logic [PULSE_BITS-1:0]            rear_level_ff, steer_level_ff;
   logic [PULSE_BITS-1:0]            left_level_in, right_level_in;
   logic [PULSE_BITS-1:0]            rear_level_in, steer_level_in;
   logic                             advance;

   trcc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   trcc_update #(
      .PULSE_BITS (PULSE_BITS)
   ) u_update (
      .cfg         (cfg),
      .mode        (in_mode_ff),
      .left_key    (in_left_key_ff),
      .right_key   (in_right_key_ff),
      .left_level  (left_level_ff),
      .right_level (right_level_ff),
      .rear_level  (rear_level_ff),
      .steer_level (steer_level_ff),
      .left_next   (left_level_in),
      .right_next  (right_level_in),
      .rear_next   (rear_level_in),
      .steer_next  (steer_level_in)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         left_level_ff  <= LEVEL_RESET;
         right_level_ff <= LEVEL_RESET;
         rear_level_ff  <= LEVEL_RESET;
         steer_level_ff <= LEVEL_RESET;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff   <= 1'b1;
            left_level_ff  <= left_level_in;
            right_level_ff <= right_level_in;
            rear_level_ff  <= rear_level_in;
            steer_level_ff <= steer_level_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_mode_ff      <= req_mode;
         in_left_key_ff  <= req_left_key;
         in_right_key_ff <= req_right_key;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_pulse  = trcc_pkg::OUT_BITS'(left_level_ff);
   assign rsp_right_pulse = trcc_pkg::OUT_BITS'(right_level_ff);
   assign rsp_rear_pulse  = trcc_pkg::OUT_BITS'(rear_level_ff);
   assign rsp_steer_pulse = trcc_pkg::OUT_BITS'(steer_level_ff);

   // The levels double as the response payload, so they may move only with a new result.
   a_levels_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(left_level_ff) && $stable(right_level_ff)
                   && $stable(rear_level_ff) && $stable(steer_level_ff))
      else $error("levels changed without a new result");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !req_ready |-> rsp_valid_ff && !rsp_ready)
      else $error("request stalled while the response side was free");

   a_reserved_mode: assert property (@(posedge clock) disable iff (reset)
      advance && (in_mode_ff == trcc_pkg::MODE_RESERVED)
      |=> $stable(left_level_ff) && $stable(right_level_ff)
          && $stable(rear_level_ff) && $stable(steer_level_ff))
      else $error("reserved mode altered a level");

endmodule

### rtl/trcc_csr.sv
module trcc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [trcc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [trcc_pkg::CSR_DATA_BITS-1:0]   csr_write_data,
   output trcc_pkg::cfg_type                    cfg
);

   trcc_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{rest_pulse:   trcc_pkg::NEUTRAL_RESET,
                     steer_center: trcc_pkg::NEUTRAL_RESET,
                     steer_limits: '0,
                     side_limits:  '0,
                     rear_limits:  '0,
                     slow_steps:   '0,
                     fast_steps:   '0};
      end else if (csr_write_enable) begin
         unique case (csr_index)
            trcc_pkg::REG_REST_PULSE:   cfg_ff.rest_pulse   <= csr_write_data[11:0];
            trcc_pkg::REG_STEER_CENTER: cfg_ff.steer_center <= csr_write_data[11:0];
            trcc_pkg::REG_STEER_LIMITS: cfg_ff.steer_limits <= csr_write_data[23:0];
            trcc_pkg::REG_SIDE_LIMITS:  cfg_ff.side_limits  <= csr_write_data[47:0];
            trcc_pkg::REG_REAR_LIMITS:  cfg_ff.rear_limits  <= csr_write_data[47:0];
            trcc_pkg::REG_SLOW_STEPS:   cfg_ff.slow_steps   <= csr_write_data[31:0];
            trcc_pkg::REG_FAST_STEPS:   cfg_ff.fast_steps   <= csr_write_data[31:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/trcc_update.sv
module trcc_update #(
   parameter int unsigned PULSE_BITS = trcc_pkg::PULSE_BITS_DEFAULT
) (
   input  trcc_pkg::cfg_type                  cfg,
   input  logic [trcc_pkg::MODE_BITS-1:0]     mode,
   input  logic [trcc_pkg::KEY_BITS-1:0]      left_key,
   input  logic [trcc_pkg::KEY_BITS-1:0]      right_key,
   input  logic [PULSE_BITS-1:0]              left_level,
   input  logic [PULSE_BITS-1:0]              right_level,
   input  logic [PULSE_BITS-1:0]              rear_level,
   input  logic [PULSE_BITS-1:0]              steer_level,
   output logic [PULSE_BITS-1:0]              left_next,
   output logic [PULSE_BITS-1:0]              right_next,
   output logic [PULSE_BITS-1:0]              rear_next,
   output logic [PULSE_BITS-1:0]              steer_next
);

   trcc_pkg::calc_type lv, rv, ev, sv;
   trcc_pkg::calc_type lv_n, rv_n, ev_n, sv_n;
   trcc_pkg::calc_type rest, center, steer_left_tgt, steer_right_tgt;
   trcc_pkg::calc_type left_max, left_min, right_max, right_min;
   trcc_pkg::calc_type rear_max, rear_min, fwd_turn, rev_turn;
   trcc_pkg::step_type ls, rs, es, ss, lf, rf, ef, sf;

   assign lv = trcc_pkg::calc_type'(left_level);
   assign rv = trcc_pkg::calc_type'(right_level);
   assign ev = trcc_pkg::calc_type'(rear_level);
   assign sv = trcc_pkg::calc_type'(steer_level);

   assign rest            = trcc_pkg::calc_type'(cfg.rest_pulse);
   assign center          = trcc_pkg::calc_type'(cfg.steer_center);
   assign steer_left_tgt  = trcc_pkg::calc_type'(cfg.steer_limits[11:0]);
   assign steer_right_tgt = trcc_pkg::calc_type'(cfg.steer_limits[23:12]);
   assign left_max        = trcc_pkg::calc_type'(cfg.side_limits[11:0]);
   assign left_min        = trcc_pkg::calc_type'(cfg.side_limits[23:12]);
   assign right_max       = trcc_pkg::calc_type'(cfg.side_limits[35:24]);
   assign right_min       = trcc_pkg::calc_type'(cfg.side_limits[47:36]);
   assign rear_max        = trcc_pkg::calc_type'(cfg.rear_limits[11:0]);
   assign rear_min        = trcc_pkg::calc_type'(cfg.rear_limits[23:12]);
   assign fwd_turn        = trcc_pkg::calc_type'(cfg.rear_limits[35:24]);
   assign rev_turn        = trcc_pkg::calc_type'(cfg.rear_limits[47:36]);

   assign ls = cfg.slow_steps[7:0];
   assign rs = cfg.slow_steps[15:8];
   assign es = cfg.slow_steps[23:16];
   assign ss = cfg.slow_steps[31:24];
   assign lf = cfg.fast_steps[7:0];
   assign rf = cfg.fast_steps[15:8];
   assign ef = cfg.fast_steps[23:16];
   assign sf = cfg.fast_steps[31:24];

   always_comb begin
      lv_n = lv;
      rv_n = rv;
      ev_n = ev;
      sv_n = sv;
      unique case (mode)
         trcc_pkg::MODE_MANUAL: begin
            unique case (left_key)
               trcc_pkg::KEY_FORWARD: begin
                  ev_n = trcc_pkg::ramp_up(ev, es, ef, rear_max, rest);
                  sv_n = trcc_pkg::toward(sv, ss, center);
               end
               trcc_pkg::KEY_BACK: begin
                  ev_n = trcc_pkg::ramp_down(ev, es, ef, rear_min, rest);
                  sv_n = trcc_pkg::toward(sv, ss, center);
               end
               trcc_pkg::KEY_FORWARD_LEFT: begin
                  ev_n = trcc_pkg::turn_fwd(ev, es, ef, fwd_turn, rest);
                  if (sv > steer_left_tgt) sv_n = trcc_pkg::down_to(sv, sf, steer_left_tgt);
               end
               trcc_pkg::KEY_FORWARD_RIGHT: begin
                  ev_n = trcc_pkg::turn_fwd(ev, es, ef, fwd_turn, rest);
                  if (sv < steer_right_tgt) sv_n = trcc_pkg::up_to(sv, sf, steer_right_tgt);
               end
               trcc_pkg::KEY_BACK_LEFT: begin
                  ev_n = trcc_pkg::turn_rev(ev, es, ef, rev_turn, rest);
                  if (sv > steer_left_tgt) sv_n = trcc_pkg::down_to(sv, sf, steer_left_tgt);
               end
               trcc_pkg::KEY_BACK_RIGHT: begin
                  ev_n = trcc_pkg::turn_rev(ev, es, ef, rev_turn, rest);
                  if (sv < steer_right_tgt) sv_n = trcc_pkg::up_to(sv, sf, steer_right_tgt);
               end
               trcc_pkg::KEY_STOP: begin
                  ev_n = trcc_pkg::toward(ev, es, rest);
                  sv_n = trcc_pkg::toward(sv, ss, center);
               end
               default: ;
            endcase
            unique case (right_key)
               trcc_pkg::KEY_UP: begin
                  lv_n = trcc_pkg::ramp_up(lv, ls, lf, left_max, rest);
                  rv_n = trcc_pkg::ramp_up(rv, rs, rf, right_max, rest);
               end
               trcc_pkg::KEY_DIVE: begin
                  lv_n = trcc_pkg::ramp_down(lv, ls, lf, left_min, rest);
                  rv_n = trcc_pkg::ramp_down(rv, rs, rf, right_min, rest);
               end
               trcc_pkg::KEY_ROLL_LEFT: begin
                  lv_n = trcc_pkg::ramp_down(lv, ls, lf, left_min, rest);
                  rv_n = trcc_pkg::ramp_up(rv, rs, rf, right_max, rest);
               end
               trcc_pkg::KEY_ROLL_RIGHT: begin
                  lv_n = trcc_pkg::ramp_up(lv, ls, lf, left_max, rest);
                  rv_n = trcc_pkg::ramp_down(rv, rs, rf, right_min, rest);
               end
               trcc_pkg::KEY_STOP: begin
                  lv_n = trcc_pkg::toward(lv, ls, rest);
                  rv_n = trcc_pkg::toward(rv, rs, rest);
               end
               default: ;
            endcase
         end
         trcc_pkg::MODE_HOVER: begin
            lv_n = trcc_pkg::toward(lv, ls, rest);
            rv_n = trcc_pkg::toward(rv, rs, rest);
            ev_n = trcc_pkg::toward(ev, es, rest);
            sv_n = trcc_pkg::toward(sv, ss, center);
         end
         trcc_pkg::MODE_ROLL_LEFT: begin
            lv_n = trcc_pkg::ramp_down(lv, ls, lf, left_min, rest);
            rv_n = trcc_pkg::ramp_up(rv, rs, rf, right_max, rest);
         end
         default: ;
      endcase
   end

   assign left_next  = PULSE_BITS'(lv_n);
   assign right_next = PULSE_BITS'(rv_n);
   assign rear_next  = PULSE_BITS'(ev_n);
   assign steer_next = PULSE_BITS'(sv_n);

endmodule
